[design/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// shared types and constants of the table constructor compactor
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_FIRST = 8'h21;
    localparam logic [7:0] CH_LAST  = 8'h7E;

    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    // result buffer depth, at least two
    localparam int TCC_OUT_DEPTH = 4;

    // comment scanner phase
    typedef enum logic [6:0] {
        PH_NORMAL    = 7'b0000001,
        PH_MINUS     = 7'b0000010,
        PH_DASH2     = 7'b0000100,
        PH_DASH2_BRK = 7'b0001000,
        PH_LINE      = 7'b0010000,
        PH_BLOCK     = 7'b0100000,
        PH_BLOCK_RB  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic        active;
        logic [15:0] nest_depth;
        logic        last_was_word;
        logic        gap_seen;
        phase_t      phase;
    } tcc_state_t;

    localparam tcc_state_t IDLE_STATE = '{
        active:        1'b0,
        nest_depth:    16'd0,
        last_was_word: 1'b0,
        gap_seen:      1'b0,
        phase:         PH_NORMAL
    };

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic       cut_short;
    } res_t;

    // results of one step: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } step_out_t;

endpackage

[design/tcc_step.sv]
// ----------------------------------------------------------------------------
// tcc_step
// one byte of compaction: next state and up to two results
// ----------------------------------------------------------------------------
module tcc_step
    import tcc_pkg::*;
(
    input  tcc_state_t cur,
    input  logic [7:0] in_char,
    input  logic       end_of_source,
    output tcc_state_t nxt,
    output step_out_t  step_out
);

    function automatic logic alnum_byte(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    logic       plain_en;
    logic       sp;
    logic       close_top;
    res_t       chr_res;
    res_t       p0;
    res_t       p1;
    logic [1:0] pcnt;

    always_comb
    begin
        nxt       = cur;
        step_out  = '0;
        plain_en  = 1'b0;
        sp        = 1'b0;
        close_top = 1'b0;
        chr_res   = '0;
        p0        = '0;
        p1        = '0;
        pcnt      = 2'd0;

        if (!cur.active)
        begin
            if (!end_of_source && in_char == CH_OPEN)
            begin
                nxt               = IDLE_STATE;
                nxt.active        = 1'b1;
                step_out.count    = 2'd1;
                step_out.res0     = '{CH_OPEN, 1'b1, 1'b0, 1'b0};
            end
        end
        else if (end_of_source)
        begin
            step_out.count = 2'd1;
            if (cur.phase == PH_MINUS)
                step_out.res0 = '{CH_MINUS, 1'b1, 1'b1, 1'b1};
            else
                step_out.res0 = '{8'h00, 1'b0, 1'b1, 1'b1};
            nxt = IDLE_STATE;
        end
        else
        begin
            unique case (cur.phase) inside
                PH_MINUS:
                begin
                    if (in_char == CH_MINUS)
                        nxt.phase = PH_DASH2;
                    else
                    begin
                        step_out.count    = 2'd1;
                        step_out.res0     = '{CH_MINUS, 1'b1, 1'b0, 1'b0};
                        nxt.last_was_word = 1'b0;
                        nxt.phase         = PH_NORMAL;
                        plain_en          = 1'b1;
                    end
                end
                PH_DASH2, PH_DASH2_BRK:
                begin
                    if (in_char == CH_LBRK)
                        nxt.phase = (cur.phase == PH_DASH2) ? PH_DASH2_BRK : PH_BLOCK;
                    else if (in_char == CH_NL)
                        nxt.phase = PH_NORMAL;
                    else
                        nxt.phase = PH_LINE;
                end
                PH_LINE:
                begin
                    if (in_char == CH_NL)
                        nxt.phase = PH_NORMAL;
                end
                PH_BLOCK:
                begin
                    if (in_char == CH_RBRK)
                        nxt.phase = PH_BLOCK_RB;
                end
                PH_BLOCK_RB:
                begin
                    nxt.phase = (in_char == CH_RBRK) ? PH_NORMAL : PH_BLOCK;
                end
                default:
                begin
                    nxt.phase = PH_NORMAL;
                    plain_en  = 1'b1;
                end
            endcase

            // plain byte handling, on top of what the phase step left
            if (plain_en)
            begin
                if (in_char < CH_FIRST || in_char > CH_LAST)
                    nxt.gap_seen = 1'b1;
                else if (in_char == CH_MINUS)
                begin
                    nxt.phase    = PH_MINUS;
                    nxt.gap_seen = 1'b0;
                end
                else
                begin
                    sp           = nxt.last_was_word && nxt.gap_seen && alnum_byte(in_char);
                    nxt.gap_seen = 1'b0;
                    close_top    = (in_char == CH_CLOSE) && (nxt.nest_depth == 16'd0);
                    chr_res      = '{in_char, 1'b1, close_top, 1'b0};
                    nxt.last_was_word = (in_char == CH_UNDER) || alnum_byte(in_char);
                    if (in_char == CH_OPEN)
                    begin
                        if (nxt.nest_depth != DEPTH_MAX)
                            nxt.nest_depth = nxt.nest_depth + 16'd1;
                    end
                    else if (in_char == CH_CLOSE)
                    begin
                        if (close_top)
                            nxt = IDLE_STATE;
                        else
                            nxt.nest_depth = nxt.nest_depth - 16'd1;
                    end
                    if (sp)
                    begin
                        p0   = '{CH_SPACE, 1'b1, 1'b0, 1'b0};
                        p1   = chr_res;
                        pcnt = 2'd2;
                    end
                    else
                    begin
                        p0   = chr_res;
                        pcnt = 2'd1;
                    end
                end

                // merge behind a released minus (no space can follow it)
                if (step_out.count == 2'd1)
                begin
                    if (pcnt != 2'd0)
                    begin
                        step_out.res1  = p0;
                        step_out.count = 2'd2;
                    end
                end
                else
                begin
                    step_out.res0  = p0;
                    step_out.res1  = p1;
                    step_out.count = pcnt;
                end
            end
        end
    end

endmodule

[design/tcc_out_fifo.sv]
// ----------------------------------------------------------------------------
// tcc_out_fifo
// result buffer taking up to two results a cycle and giving one unless out_stall is high
// ----------------------------------------------------------------------------
module tcc_out_fifo
    import tcc_pkg::*;
#(
    parameter int DEPTH = TCC_OUT_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  step_out_t  push_data,
    output logic       room,
    output logic       out_valid,
    input  logic       out_stall,
    output res_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    res_t             buf_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       push_cnt;
    logic             pop;

    assign push_cnt  = push ? push_data.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign head      = buf_reg[rd_ptr_reg];
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_p1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            buf_reg[wr_ptr_reg] <= push_data.res0;
        if (push_cnt == 2'd2)
            buf_reg[wr_ptr_p1] <= push_data.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result buffer count above depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("push into a buffer without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && pop) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("count not reduced by a lone pop");

endmodule

[design/table_constructor_compactor_core.sv]
// ----------------------------------------------------------------------------
// table_constructor_compactor_core
// compacts table constructor source text one byte at a time
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  input   | in_valid / in_stall        | in_char, end_of_source
//  output  | out_valid / out_stall      | out_char, char_valid, last, cut_short
//
//  one byte is taken per cycle while in_stall is low
//  the byte sits in an input register, the step logic updates the scanner state
//  and writes zero, one or two results into a small result buffer
//  in_stall rises while the buffer cannot take two more results, so a run of
//  two-result bytes under a stalled output is bounded by the buffer depth
//  rst_n clears the scanner to idle and empties both stages at once
//
module table_constructor_compactor_core
    import tcc_pkg::*;
#(
    parameter int OUT_DEPTH = TCC_OUT_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       end_of_source,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       last,
    output logic       cut_short
);

    // input register stage
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       eos_reg;

    // scanner state
    tcc_state_t state_reg;
    tcc_state_t state_next;

    step_out_t  step_out;
    res_t       head;
    logic       room;
    logic       fire;
    logic       take;

    // the held byte is processed once the buffer has room for two results
    assign fire     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    // payload of the input register needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_char_reg <= in_char;
            eos_reg     <= end_of_source;
        end
    end

    tcc_step u_step (
        .cur           (state_reg),
        .in_char       (in_char_reg),
        .end_of_source (eos_reg),
        .nxt           (state_next),
        .step_out      (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE_STATE;
        else if (fire)
            state_reg <= state_next;
    end

    // result buffer, one transaction per cycle on the output side while out_stall is low
    tcc_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (step_out),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_char   = head.out_char;
    assign char_valid = head.char_valid;
    assign last       = head.last;
    assign cut_short  = head.cut_short;

    // end of source always returns the scanner to idle
    a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eos_reg) |=> !state_reg.active)
        else $error("scanner active after end of source");

    // an active scanner gives exactly one result at end of source
    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eos_reg && state_reg.active) |-> step_out.count == 2'd1)
        else $error("end of source without a single closing result");

    // idle scanner holds no nesting
    a_idle_depth: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.active |-> (state_reg.nest_depth == 16'd0 &&
                               state_reg.phase == PH_NORMAL))
        else $error("idle scanner carries leftover state");

endmodule
